// ----- sv/wma_pkg.sv -----
// Shared constants for the windowed moving average block.
package wma_pkg;

  // Width and reset value of the window size register.
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] WIN_SIZE_RST = 7'd16;

endpackage

// ----- sv/windowed_moving_average_unit.sv -----
// Windowed moving average with warm-up: ring RAM, running sum, serial divider.
// One word is in flight at a time: accept, then ST_UPD (ring update and running sum),
//   then ST_DIV, where the bit-serial divider works through the sum bits MSB first.
// The next word is taken while a finished result waits in the output register;
//   a result that finds the output register still full waits in ST_HOLD.
// Reset (sync, active low) clears sum, pointer, fill flag and window size (16).
module windowed_moving_average_unit #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_window_full,
  input  logic                          cfg_we,
  input  logic [wma_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + PTR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [wma_pkg::CFG_W-1:0]     win_r, win_nxt;
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic                          fill_r, fill_nxt;
  logic [PTR_W-1:0]              cur_r, cur_nxt;
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic                          full_r, full_nxt;

  logic [31:0]                   win_ext;
  logic [CNT_W-1:0]              size_eff;
  logic [PTR_W-1:0]              ptr_eff;
  logic [CNT_W-1:0]              cur_inc;
  logic                          in_acc;
  logic                          load_out;
  logic                          div_start;
  logic [CNT_W-1:0]              div_dvs;
  logic                          div_done;
  logic signed [SUM_W-1:0]       div_q;
  logic signed [SAMPLE_BITS-1:0] old_smp;

  // zero acts as one, anything above the ring depth as the ring depth
  assign win_ext  = 32'(win_r);
  assign size_eff = (win_r == '0) ? CNT_W'(1) :
                    (win_ext > 32'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(win_r);
  assign ptr_eff  = (CNT_W'(ptr_r) >= size_eff) ? '0 : ptr_r;
  assign cur_inc  = CNT_W'(cur_r) + CNT_W'(1);

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_out = ((state_r == ST_DIV && div_done) || state_r == ST_HOLD) &&
                    (!out_valid_r || out_ready);

  assign div_start = (state_r == ST_UPD);
  assign div_dvs   = fill_r ? size_eff : cur_inc;

  // Ring read is issued at accept and consumed in ST_UPD; the write of the
  // same entry lands in ST_UPD too, long before the next word can read it.
  wma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == ST_UPD),
    .waddr (cur_r),
    .wdata (smp_r),
    .raddr (ptr_eff),
    .rdata (old_smp)
  );

  // divider loads the updated sum in ST_UPD
  wma_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    smp_nxt       = smp_r;
    out_valid_nxt = out_valid_r;
    avg_nxt       = avg_r;
    full_nxt      = full_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_nxt   = ptr_eff;
          smp_nxt   = in_sample;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // old sample only counts once the window has filled
        sum_nxt = sum_r + SUM_W'(smp_r) - (fill_r ? SUM_W'(old_smp) : SUM_W'(0));
        if (cur_inc >= size_eff) begin
          ptr_nxt  = '0;
          fill_nxt = 1'b1;
        end else begin
          ptr_nxt = cur_inc[PTR_W-1:0];
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = load_out ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      avg_nxt       = SAMPLE_BITS'(div_q);
      full_nxt      = fill_r;
    end

    // restart warm-up on any write
    if (cfg_we) begin
      win_nxt  = cfg_wdata;
      ptr_nxt  = '0;
      sum_nxt  = '0;
      fill_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= wma_pkg::WIN_SIZE_RST;
      ptr_r       <= '0;
      sum_r       <= '0;
      fill_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r  <= cur_nxt;
    smp_r  <= smp_nxt;
    avg_r  <= avg_nxt;
    full_r <= full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_average     = avg_r;
  assign out_window_full = full_r;

endmodule

// ----- sv/wma_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module wma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/wma_div.sv -----
// Bit-serial restoring divider: signed dividend by unsigned divisor, truncating.
module wma_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] mag_r, mag_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;

  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // one quotient bit per cycle, MSB first; magnitude and quotient share mag_r
  assign rem_sh = {rem_r, mag_r[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      neg_nxt  = dividend[DVD_W-1];
      mag_nxt  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
      mag_nxt = {mag_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

// ----- sv/wma_chk.sv -----
// Port-level checker for the windowed moving average, bound to the top level.
module wma_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_average,
  input logic                   out_window_full
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_average) && $stable(out_window_full))
    else $error("result word changed while stalled");

  // one word in flight: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // a result cannot appear in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind windowed_moving_average_unit wma_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wma_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_average     (out_average),
  .out_window_full (out_window_full)
);
